@@ rtl/hstl_pkg.sv @@
package hstl_pkg;

	localparam int SERIES    = 64;
	localparam int POINTS    = 256;
	localparam int MEM_DEPTH = SERIES * POINTS;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int SER_W     = (SERIES > 1) ? $clog2(SERIES) : 1;
	localparam int IDX_W     = $clog2(POINTS);
	localparam int LEN_W     = $clog2(POINTS + 1);
	localparam int HINT_W    = 8;
	localparam int CMP_W     = ((LEN_W > HINT_W) ? LEN_W : HINT_W) + 2;
	localparam int STEP_W    = 5;

	typedef enum logic [1:0] {
		ACT_CLEAR,
		ACT_APPEND,
		ACT_QUERY,
		ACT_NONE
	} act_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_EMPTY,
		ST_FULL,
		ST_ORDER
	} st_t;

	// datapath operation of a microstep
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_LOADLEN,
		OP_MISC,
		OP_FULL,
		OP_ORDER,
		OP_EMPTY,
		OP_WRITE,
		OP_DATA,
		OP_EMIT
	} op_t;

	// jump condition
	typedef enum logic [3:0] {
		J_NEVER,
		J_ALWAYS,
		J_NOREQ,
		J_MISC,
		J_QUERY,
		J_FULL,
		J_ORDER,
		J_EMPTY,
		J_HIT0,
		J_HIT1,
		J_FIRST,
		J_SMORE,
		J_OUTBUSY
	} jmp_t;

	// point memory read index source
	typedef enum logic [2:0] {
		A_HINT,
		A_HINT1,
		A_HINT2,
		A_ZERO,
		A_MID,
		A_POS,
		A_LENM1
	} adr_t;

	// position register source
	typedef enum logic [2:0] {
		P_KEEP,
		P_HINT,
		P_HINT1,
		P_ZERO,
		P_LOM1
	} psel_t;

	// search bounds control
	typedef enum logic [1:0] {
		SR_HOLD,
		SR_INIT,
		SR_STEP
	} sr_t;

	typedef struct packed {
		op_t               op;
		jmp_t              jmp;
		adr_t              adr;
		psel_t             psel;
		sr_t               sr;
		logic              flag_ld;
		logic              last;
		logic [STEP_W-1:0] tgt;
	} ucode_t;

	typedef struct packed {
		logic noreq;
		logic misc;
		logic query;
		logic full;
		logic order;
		logic empty;
		logic hit0;
		logic hit1;
		logic first;
		logic smore;
		logic outbusy;
	} flags_t;

	localparam logic [STEP_W-1:0] S_IDLE  = 5'd0;
	localparam logic [STEP_W-1:0] S_LEN   = 5'd1;
	localparam logic [STEP_W-1:0] S_DISP  = 5'd2;
	localparam logic [STEP_W-1:0] S_APP0  = 5'd3;
	localparam logic [STEP_W-1:0] S_APP1  = 5'd4;
	localparam logic [STEP_W-1:0] S_APP2  = 5'd5;
	localparam logic [STEP_W-1:0] S_Q0    = 5'd6;
	localparam logic [STEP_W-1:0] S_Q1    = 5'd7;
	localparam logic [STEP_W-1:0] S_Q2    = 5'd8;
	localparam logic [STEP_W-1:0] S_Q3    = 5'd9;
	localparam logic [STEP_W-1:0] S_Q4    = 5'd10;
	localparam logic [STEP_W-1:0] S_SRCH  = 5'd11;
	localparam logic [STEP_W-1:0] S_DATA  = 5'd12;
	localparam logic [STEP_W-1:0] S_DRES  = 5'd13;
	localparam logic [STEP_W-1:0] S_MISC  = 5'd14;
	localparam logic [STEP_W-1:0] S_FULLR = 5'd15;
	localparam logic [STEP_W-1:0] S_ORDR  = 5'd16;
	localparam logic [STEP_W-1:0] S_EMPTR = 5'd17;
	localparam logic [STEP_W-1:0] S_OUT   = 5'd18;

	function automatic ucode_t uw(input op_t op, input jmp_t jmp, input adr_t adr,
			input psel_t psel, input sr_t sr, input logic flag_ld, input logic last,
			input logic [STEP_W-1:0] tgt);
		ucode_t w;
		w.op      = op;
		w.jmp     = jmp;
		w.adr     = adr;
		w.psel    = psel;
		w.sr      = sr;
		w.flag_ld = flag_ld;
		w.last    = last;
		w.tgt     = tgt;
		return w;
	endfunction

	// control store
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] pc);
		ucode_t w;
		case (pc)
			S_IDLE:  w = uw(OP_ACCEPT,  J_NOREQ,   A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_IDLE);
			S_LEN:   w = uw(OP_LOADLEN, J_MISC,    A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_MISC);
			S_DISP:  w = uw(OP_NONE,    J_QUERY,   A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_Q0);
			S_APP0:  w = uw(OP_NONE,    J_FULL,    A_LENM1, P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_FULLR);
			S_APP1:  w = uw(OP_NONE,    J_ORDER,   A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_ORDR);
			S_APP2:  w = uw(OP_WRITE,   J_ALWAYS,  A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_OUT);
			S_Q0:    w = uw(OP_NONE,    J_EMPTY,   A_HINT,  P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_EMPTR);
			S_Q1:    w = uw(OP_NONE,    J_NEVER,   A_HINT1, P_KEEP,  SR_HOLD, 1'b1, 1'b0, S_IDLE);
			S_Q2:    w = uw(OP_NONE,    J_HIT0,    A_HINT2, P_HINT,  SR_HOLD, 1'b1, 1'b0, S_DATA);
			S_Q3:    w = uw(OP_NONE,    J_HIT1,    A_ZERO,  P_HINT1, SR_HOLD, 1'b0, 1'b0, S_DATA);
			S_Q4:    w = uw(OP_NONE,    J_FIRST,   A_MID,   P_ZERO,  SR_INIT, 1'b0, 1'b0, S_DATA);
			S_SRCH:  w = uw(OP_NONE,    J_SMORE,   A_MID,   P_LOM1,  SR_STEP, 1'b0, 1'b0, S_SRCH);
			S_DATA:  w = uw(OP_NONE,    J_NEVER,   A_POS,   P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_IDLE);
			S_DRES:  w = uw(OP_DATA,    J_ALWAYS,  A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_OUT);
			S_MISC:  w = uw(OP_MISC,    J_ALWAYS,  A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_OUT);
			S_FULLR: w = uw(OP_FULL,    J_ALWAYS,  A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_OUT);
			S_ORDR:  w = uw(OP_ORDER,   J_ALWAYS,  A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_OUT);
			S_EMPTR: w = uw(OP_EMPTY,   J_NEVER,   A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b0, S_IDLE);
			S_OUT:   w = uw(OP_EMIT,    J_OUTBUSY, A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b1, S_OUT);
			default: w = uw(OP_NONE,    J_NEVER,   A_ZERO,  P_KEEP,  SR_HOLD, 1'b0, 1'b1, S_IDLE);
		endcase
		return w;
	endfunction

endpackage

@@ rtl/hstl_if.sv @@
interface hstl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [5:0]  series;
	logic [31:0] age;
	logic [31:0] point_value;
	logic [7:0]  hint_in;

	modport source (output valid, action, series, age, point_value, hint_in, input ready);
	modport sink (input valid, action, series, age, point_value, hint_in, output ready);
endinterface

interface hstl_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] value_out;
	logic [7:0]  hint_out;
	logic [1:0]  status;

	modport source (output valid, value_out, hint_out, status, input ready);
	modport sink (input valid, value_out, hint_out, status, output ready);
endinterface

@@ rtl/hinted_step_table_lookup_top.sv @@
// Hinted step-table lookup: per series, a list of (age, value) points appended in
// non-descending age order; a query returns the value of the last point at or before
// the age (the first point if the age is at or before that one) plus the index used,
// to be passed back as the hint. One request is worked on at a time by a microcoded
// sequencer driving a point memory with one registered read port. A query tries the
// hinted point, then the point after it, then the first point, and otherwise runs a
// binary search; each search step is one read of the point memory. The next request
// can be taken in the cycle after the result is loaded into the output register, even
// if it is not yet taken.
// Lengths reset to zero at once through per-series valid bits; there is no clearing
// pass, and the point memory itself is never cleared.
module hinted_step_table_lookup_top (
	input logic       clk,
	input logic       arst_n,
	hstl_req_if.sink  req,
	hstl_rsp_if.source rsp
);
	import hstl_pkg::*;

	flags_t flags;
	ucode_t ctl;

	hstl_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.flags (flags),
		.ctl   (ctl)
	);

	// request fields
	act_t        act_q;
	logic [5:0]  ser_q;
	logic [31:0] age_q;
	logic [31:0] val_q;
	logic [7:0]  hint_q;

	// series lengths
	logic [LEN_W-1:0] len_mem [SERIES];
	logic [SERIES-1:0] len_vld_q;
	logic [LEN_W-1:0] len_rd_q;
	logic             len_rv_q;
	logic [LEN_W-1:0] len_q;

	// point store
	logic [31:0] age_mem  [MEM_DEPTH];
	logic [31:0] data_mem [MEM_DEPTH];
	logic [31:0] rd_age_q;
	logic [31:0] rd_data_q;

	// search state
	logic             f_q;
	logic [IDX_W-1:0] pos_q;
	logic [LEN_W-1:0] lo_q, hi_q, lo_d, hi_d, mid_q, mid_d;

	// result and output registers
	logic [31:0] res_val_q, rsp_val_q;
	logic [7:0]  res_hint_q, rsp_hint_q;
	st_t         res_st_q, rsp_st_q;
	logic        rsp_vld_q;

	logic              acc, oor, clr, len_we, emit;
	logic [CMP_W-1:0]  hint_w, len_w;
	logic [IDX_W-1:0]  rd_idx;
	logic [ADDR_W-1:0] base, rd_addr, wr_addr;
	st_t               misc_st;

	assign req.ready = (ctl.op == OP_ACCEPT);
	assign acc       = req.valid && req.ready;

	assign oor    = int'(ser_q) >= SERIES;
	assign clr    = (ctl.op == OP_MISC) && (act_q == ACT_CLEAR);
	assign len_we = (ctl.op == OP_WRITE);
	assign emit   = (ctl.op == OP_EMIT) && !flags.outbusy;
	assign hint_w = CMP_W'(hint_q);
	assign len_w  = CMP_W'(len_q);

	always_ff @(posedge clk) begin
		if (acc) begin
			act_q  <= act_t'(req.action);
			ser_q  <= req.series;
			age_q  <= req.age;
			val_q  <= req.point_value;
			hint_q <= req.hint_in;
		end
	end

	// length store: read on acceptance, written on append
	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[SER_W'(ser_q)] <= LEN_W'(len_q + LEN_W'(1));
		end
		if (acc) begin
			len_rd_q <= len_mem[SER_W'(req.series)];
			len_rv_q <= len_vld_q[SER_W'(req.series)];
		end
		if (ctl.op == OP_LOADLEN) begin
			len_q <= len_rv_q ? len_rd_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
		end else if (clr) begin
			len_vld_q <= '0;
		end else if (len_we) begin
			len_vld_q[SER_W'(ser_q)] <= 1'b1;
		end
	end

	// search bounds, next value
	always_comb begin
		mid_q = lo_q + ((hi_q - lo_q) >> 1);
		lo_d  = lo_q;
		hi_d  = hi_q;
		case (ctl.sr)
			SR_INIT: begin
				lo_d = LEN_W'(1);
				hi_d = len_q;
			end
			SR_STEP: begin
				if (lo_q < hi_q) begin
					if (rd_age_q > age_q) begin
						hi_d = mid_q;
					end else begin
						lo_d = mid_q + LEN_W'(1);
					end
				end
			end
			default: ;
		endcase
		mid_d = lo_d + ((hi_d - lo_d) >> 1);
	end

	always_comb begin
		case (ctl.adr)
			A_HINT:  rd_idx = IDX_W'(hint_w);
			A_HINT1: rd_idx = IDX_W'(hint_w + CMP_W'(1));
			A_HINT2: rd_idx = IDX_W'(hint_w + CMP_W'(2));
			A_MID:   rd_idx = IDX_W'(mid_d);
			A_POS:   rd_idx = pos_q;
			A_LENM1: rd_idx = IDX_W'(len_q - LEN_W'(1));
			default: rd_idx = '0;
		endcase
	end

	assign base    = ADDR_W'(int'(ser_q) * POINTS);
	assign rd_addr = base + ADDR_W'(rd_idx);
	assign wr_addr = base + ADDR_W'(IDX_W'(len_q));

	always_ff @(posedge clk) begin
		if (len_we) begin
			age_mem[wr_addr]  <= age_q;
			data_mem[wr_addr] <= val_q;
		end
		rd_age_q  <= age_mem[rd_addr];
		rd_data_q <= data_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		hi_q <= hi_d;
		if (ctl.flag_ld) begin
			f_q <= age_q >= rd_age_q;
		end
		case (ctl.psel)
			P_HINT:  pos_q <= IDX_W'(hint_w);
			P_HINT1: pos_q <= IDX_W'(hint_w + CMP_W'(1));
			P_ZERO:  pos_q <= '0;
			P_LOM1:  pos_q <= IDX_W'(lo_q - LEN_W'(1));
			default: ;
		endcase
	end

	// jump conditions
	always_comb begin
		flags.noreq   = !req.valid;
		flags.misc    = (act_q == ACT_CLEAR) || (act_q == ACT_NONE) || oor;
		flags.query   = (act_q == ACT_QUERY);
		flags.full    = len_q >= LEN_W'(POINTS);
		flags.order   = (len_q != '0) && (age_q < rd_age_q);
		flags.empty   = (len_q == '0);
		flags.hit0    = (hint_w + CMP_W'(1) < len_w) && f_q && (age_q < rd_age_q);
		flags.hit1    = (hint_w + CMP_W'(2) < len_w) && f_q && (age_q < rd_age_q);
		flags.first   = age_q <= rd_age_q;
		flags.smore   = lo_q < hi_q;
		flags.outbusy = rsp_vld_q && !rsp.ready;
	end

	// misc path: append (out-of-range series) reports full, query reports empty, clear and none report ok
	always_comb begin
		if (act_q == ACT_APPEND) begin
			misc_st = ST_FULL;
		end else if (act_q == ACT_QUERY) begin
			misc_st = ST_EMPTY;
		end else begin
			misc_st = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_MISC: begin
				res_val_q  <= '0;
				res_hint_q <= '0;
				res_st_q   <= misc_st;
			end
			OP_FULL: begin
				res_val_q  <= '0;
				res_hint_q <= '0;
				res_st_q   <= ST_FULL;
			end
			OP_ORDER: begin
				res_val_q  <= '0;
				res_hint_q <= '0;
				res_st_q   <= ST_ORDER;
			end
			OP_EMPTY: begin
				res_val_q  <= '0;
				res_hint_q <= '0;
				res_st_q   <= ST_EMPTY;
			end
			OP_WRITE: begin
				res_val_q  <= '0;
				res_hint_q <= 8'(len_q);
				res_st_q   <= ST_OK;
			end
			OP_DATA: begin
				res_val_q  <= rd_data_q;
				res_hint_q <= 8'(pos_q);
				res_st_q   <= ST_OK;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (emit) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_val_q  <= res_val_q;
			rsp_hint_q <= res_hint_q;
			rsp_st_q   <= res_st_q;
		end
	end

	assign rsp.valid     = rsp_vld_q;
	assign rsp.value_out = rsp_val_q;
	assign rsp.hint_out  = rsp_hint_q;
	assign rsp.status    = rsp_st_q;

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready)
		else $error("request taken while another is in flight");

	a_srch_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.sr == SR_STEP) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_DATA) |-> (CMP_W'(pos_q) < len_w))
		else $error("query position beyond series length");

	a_wr_room: assert property (@(posedge clk) disable iff (!arst_n)
		len_we |-> ((len_q < LEN_W'(POINTS)) && !oor))
		else $error("append into full or invalid series");

endmodule

@@ rtl/hstl_seq.sv @@
module hstl_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  hstl_pkg::flags_t flags,
	output hstl_pkg::ucode_t ctl
);
	import hstl_pkg::*;

	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_d;
	logic              take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		ctl = ucode_rom(pc_q);
		case (ctl.jmp)
			J_NEVER:   take = 1'b0;
			J_ALWAYS:  take = 1'b1;
			J_NOREQ:   take = flags.noreq;
			J_MISC:    take = flags.misc;
			J_QUERY:   take = flags.query;
			J_FULL:    take = flags.full;
			J_ORDER:   take = flags.order;
			J_EMPTY:   take = flags.empty;
			J_HIT0:    take = flags.hit0;
			J_HIT1:    take = flags.hit1;
			J_FIRST:   take = flags.first;
			J_SMORE:   take = flags.smore;
			J_OUTBUSY: take = flags.outbusy;
			default:   take = 1'b0;
		endcase
		if (take) begin
			pc_d = ctl.tgt;
		end else if (ctl.last) begin
			pc_d = S_IDLE;
		end else begin
			pc_d = pc_q + STEP_W'(1);
		end
	end

endmodule

@@ bench/tb_hinted_step_table_lookup_top.sv @@
module tb_hinted_step_table_lookup_top;
	import hstl_pkg::*;

	// Cycles with no request and no result taken before the run is called hung.
	// It lies well above the slowest request and the long receiver hold.
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int FILL_SERIES = 40;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		act_t        action;
		logic [5:0]  series;
		logic [31:0] age;
		logic [31:0] pt_value;
		logic [7:0]  hint;
	} lookup_req_t;

	typedef struct {
		logic [31:0] value;
		logic [7:0]  hint;
		st_t         status;
	} lookup_result_t;

	logic clk;
	logic arst_n;

	hstl_req_if req_bus ();
	hstl_rsp_if rsp_bus ();

	hinted_step_table_lookup_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// Shadow of the point tables. Only entries below a series length are read.
	logic [31:0] pt_age [SERIES][POINTS];
	logic [31:0] pt_val [SERIES][POINTS];
	int unsigned ser_len [SERIES];
	// last position answered per series; stimulus feeds it back as the hint
	logic [7:0]  series_hint [SERIES] = '{default: 8'h00};

	lookup_req_t    pending_reqs [$];
	lookup_result_t expected_results [$];

	int errors = 0;
	int tx_idle_pct;
	int rx_idle_pct;
	int holds_asked;
	int holds_done;
	int hold_left;
	int stall_cycles = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void add_pending(input lookup_req_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	function automatic void add_expected(input lookup_result_t res);
		expected_results.insert(expected_results.size(), res);
	endfunction

	// Step lookup: hinted slot, then the slot after it, then the first point,
	// then an upper-bound binary search over [1, len].
	function automatic int unsigned locate_step(input int unsigned s, input int unsigned len,
			input logic [31:0] a, input int unsigned h);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		if (h + 1 < len && a >= pt_age[s][h] && a < pt_age[s][h + 1])
			return h;
		if (h + 2 < len && a >= pt_age[s][h + 1] && a < pt_age[s][h + 2])
			return h + 1;
		if (a <= pt_age[s][0])
			return 0;
		lo = 1;
		hi = len;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (pt_age[s][mid] > a)
				hi = mid;
			else
				lo = mid + 1;
		end
		return lo - 1;
	endfunction

	// Applies one accepted request to the shadow tables and returns its result.
	function automatic lookup_result_t apply_request(input lookup_req_t r);
		lookup_result_t res;
		int unsigned s;
		int unsigned len;
		int unsigned pos;
		res.value = '0;
		res.hint = '0;
		res.status = ST_OK;
		s = r.series;
		len = ser_len[s];
		case (r.action)
			ACT_CLEAR: begin
				// lengths only; stale points stay but are never read
				foreach (ser_len[i])
					ser_len[i] = 0;
			end
			ACT_APPEND: begin
				if (len >= POINTS) begin
					res.status = ST_FULL;
				end else if (len > 0 && r.age < pt_age[s][len - 1]) begin
					// equal age is fine, only a step backwards is refused
					res.status = ST_ORDER;
				end else begin
					pt_age[s][len] = r.age;
					pt_val[s][len] = r.pt_value;
					ser_len[s] = len + 1;
					res.hint = len[7:0];
				end
			end
			ACT_QUERY: begin
				if (len == 0) begin
					res.status = ST_EMPTY;
				end else begin
					pos = locate_step(s, len, r.age, r.hint);
					res.value = pt_val[s][pos];
					res.hint = pos[7:0];
					series_hint[s] = pos[7:0];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic queue_request(input act_t a, input logic [5:0] s, input logic [31:0] age,
			input logic [31:0] val, input logic [7:0] h);
		lookup_req_t r;
		r.action = a;
		r.series = s;
		r.age = age;
		r.pt_value = val;
		r.hint = h;
		add_pending(r);
	endtask

	// One random request. With target < 0 it works a few busy series plus noise;
	// otherwise it piles mostly ordered appends and queries onto the target series.
	// Shapes are taken from the shadow state, which may lag by the request in flight.
	task automatic random_request(output lookup_req_t r, input int target);
		int unsigned s;
		int unsigned len;
		int unsigned pick;
		int unsigned idx;
		int unsigned append_cut;
		logic [31:0] last_age;
		logic [31:0] step;
		r.action = ACT_QUERY;
		r.age = $urandom;
		r.pt_value = $urandom;
		r.hint = 8'($urandom_range(255));
		pick = $urandom_range(99);
		append_cut = (target >= 0) ? 73 : 45;
		if (target >= 0) begin
			s = target;
		end else if ($urandom_range(99) < 85) begin
			case ($urandom_range(4))
				0: s = 0;
				1: s = 1;
				2: s = 2;
				3: s = 3;
				default: s = SERIES - 1;
			endcase
		end else begin
			s = $urandom_range(SERIES - 1);
		end
		r.series = s[5:0];
		len = ser_len[s];
		if (target < 0 && pick < 1) begin
			r.action = ACT_CLEAR;
		end else if (pick < 3) begin
			r.action = ACT_NONE;
		end else if (pick < append_cut) begin
			r.action = ACT_APPEND;
			if (len == 0) begin
				if ($urandom_range(1) == 1)
					r.age = $urandom_range(32'h00FF_FFFF);
			end else if ($urandom_range(99) >= 8) begin
				// ordered append; a zero step repeats the previous age
				last_age = pt_age[s][len - 1];
				step = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(32'h0003_0000, 1);
				r.age = (last_age > ~step) ? last_age : last_age + step;
			end
			// otherwise a fully random age, most likely out of order
		end else if (len != 0 && $urandom_range(99) >= 8) begin
			idx = $urandom_range(len - 1);
			case ($urandom_range(3))
				0: r.age = pt_age[s][idx];
				1: r.age = pt_age[s][idx] - 32'd1;
				2: r.age = pt_age[s][idx] + $urandom_range(32'h0001_0000);
				default: ;
			endcase
			case ($urandom_range(4))
				0, 1: r.hint = series_hint[s];
				2: r.hint = series_hint[s] + 8'd1;
				3: r.hint = idx[7:0];
				default: ;
			endcase
		end
	endtask

	task automatic feed_random(input int count, input int target);
		lookup_req_t r;
		for (int n = 0; n < count; n++) begin
			while (pending_reqs.size() != 0)
				@(negedge clk);
			random_request(r, target);
			add_pending(r);
		end
	endtask

	// Returns once nothing is queued, offered or awaited.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || req_bus.valid || expected_results.size() != 0);
	endtask

	// Request driver: takes the next queued request once the current one is gone,
	// skipping cycles at the sender idle rate.
	always @(posedge clk or negedge arst_n) begin : drive_blk
		lookup_req_t nxt;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.action <= ACT_NONE;
			req_bus.series <= '0;
			req_bus.age <= '0;
			req_bus.point_value <= '0;
			req_bus.hint_in <= '0;
		end else if (!req_bus.valid || req_bus.ready) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				nxt = pending_reqs.pop_front();
				req_bus.valid <= 1'b1;
				req_bus.action <= nxt.action;
				req_bus.series <= nxt.series;
				req_bus.age <= nxt.age;
				req_bus.point_value <= nxt.pt_value;
				req_bus.hint_in <= nxt.hint;
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random back-pressure, plus a long hold each time one is asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			hold_left <= 0;
			holds_done <= 0;
		end else if (holds_done != holds_asked) begin
			holds_done <= holds_asked;
			hold_left <= HOLD_CYCLES;
			rsp_bus.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Monitor: predicts on each accepted request, checks each accepted result
	// against the oldest prediction, and watches for a hung block.
	always @(posedge clk) begin : monitor_blk
		lookup_req_t seen;
		lookup_result_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (req_bus.valid && req_bus.ready) begin
				seen.action = act_t'(req_bus.action);
				seen.series = req_bus.series;
				seen.age = req_bus.age;
				seen.pt_value = req_bus.point_value;
				seen.hint = req_bus.hint_in;
				add_expected(apply_request(seen));
				moved = 1'b1;
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				moved = 1'b1;
				if (expected_results.size() == 0) begin
					$error("unexpected result: value_out %h hint_out %0d status %0d",
						rsp_bus.value_out, rsp_bus.hint_out, rsp_bus.status);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (rsp_bus.value_out !== want.value) begin
						$error("value_out: expected %h, got %h", want.value, rsp_bus.value_out);
						errors++;
					end
					if (rsp_bus.hint_out !== want.hint) begin
						$error("hint_out: expected %0d, got %0d", want.hint, rsp_bus.hint_out);
						errors++;
					end
					if (rsp_bus.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_bus.status);
						errors++;
					end
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		lookup_req_t r;
		int full_extra;
		arst_n = 1'b0;
		holds_asked = 0;
		tx_idle_pct = 8;
		rx_idle_pct = 49;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty series, unused action, ordered and equal-age appends,
		// an out-of-order append, hint hit, next slot, first point, search, past end.
		queue_request(ACT_QUERY,  6'd0,  32'hFFFF_FFFF, 32'h0,         8'hFF);
		queue_request(ACT_NONE,   6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		queue_request(ACT_NONE,   6'd0,  32'h0,         32'h0,         8'h00);
		queue_request(ACT_APPEND, 6'd0,  32'h0000_0000, 32'hFFFF_FFFF, 8'h00);
		queue_request(ACT_APPEND, 6'd0,  32'h0001_0000, 32'h1234_5678, 8'h00);
		queue_request(ACT_APPEND, 6'd0,  32'h0001_0000, 32'h0000_0002, 8'h00);
		queue_request(ACT_APPEND, 6'd0,  32'h0005_8000, 32'h0000_0003, 8'h00);
		queue_request(ACT_APPEND, 6'd0,  32'hFFFF_FFFF, 32'h0000_0004, 8'h00);
		queue_request(ACT_APPEND, 6'd0,  32'h0004_0000, 32'h0000_0005, 8'h00);
		queue_request(ACT_APPEND, 6'd63, 32'h8000_0000, 32'hA5A5_A5A5, 8'h00);
		queue_request(ACT_QUERY,  6'd0,  32'h0000_0000, 32'h0,         8'd0);
		queue_request(ACT_QUERY,  6'd0,  32'h0001_8000, 32'h0,         8'd2);
		queue_request(ACT_QUERY,  6'd0,  32'h0001_8000, 32'h0,         8'd1);
		queue_request(ACT_QUERY,  6'd0,  32'h6000_0000, 32'h0,         8'hFF);
		queue_request(ACT_QUERY,  6'd0,  32'hFFFF_FFFF, 32'h0,         8'd0);
		queue_request(ACT_QUERY,  6'd0,  32'h0000_8000, 32'h0,         8'hC8);
		queue_request(ACT_QUERY,  6'd63, 32'h0000_0000, 32'h0,         8'd0);
		queue_request(ACT_QUERY,  6'd63, 32'h8000_0000, 32'h0,         8'd7);
		queue_request(ACT_CLEAR,  6'd21, 32'h0,         32'h0,         8'h00);
		queue_request(ACT_QUERY,  6'd0,  32'h0001_0000, 32'h0,         8'd3);
		queue_request(ACT_APPEND, 6'd0,  32'h7FFF_FFFF, 32'h5A5A_5A5A, 8'h00);
		queue_request(ACT_QUERY,  6'd0,  32'h0000_0000, 32'h0,         8'd0);
		queue_request(ACT_QUERY,  6'd0,  32'hFFFF_FFFF, 32'h0,         8'd1);
		drain();

		// sender mostly busy, receiver idles about half the time
		feed_random(110, -1);
		drain();

		tx_idle_pct = 49;
		rx_idle_pct = 8;
		feed_random(110, -1);
		drain();

		// No idling. Start from empty tables, then hold the receiver off for a long
		// stretch while requests keep coming, and fill one series past its capacity
		// so that deep searches and full-series refusals both show up.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_request(ACT_CLEAR, 6'd0, 32'h0, 32'h0, 8'h00);
		holds_asked = holds_asked + 1;
		full_extra = 0;
		while (full_extra < 8) begin
			while (pending_reqs.size() != 0)
				@(negedge clk);
			random_request(r, FILL_SERIES);
			if (ser_len[FILL_SERIES] == POINTS && r.action == ACT_APPEND)
				full_extra++;
			add_pending(r);
		end
		drain();

		// let any late, unexpected result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/hstl_pkg.sv
rtl/hstl_if.sv
rtl/hstl_seq.sv
rtl/hinted_step_table_lookup_top.sv
bench/tb_hinted_step_table_lookup_top.sv
